FILE: hdl/cbe_pkg.sv
// Shared types and constants for the cubic Bezier easing evaluator.
// Holds fixed-point formats, sequencer state codes and register indexes.
// No dependencies.
package cbe_pkg;

  // Formats: progress in Q16, internal values in signed Q4.28
  localparam int FRAC_BITS    = 16;
  localparam int NEWTON_STEPS = 4;
  localparam int QBITS        = 28;
  localparam int PROG_W       = 17;
  localparam int EASED_W      = 18;
  localparam int CTRL_W       = 7;
  localparam int CFG_IDX_W    = 3;

  // Datapath widths
  localparam int T_W     = 32;            // curve parameter t
  localparam int MAG_W   = 33;            // magnitude of an intermediate
  localparam int ACC_W   = MAG_W + 1;     // signed intermediate
  localparam int ADD_W   = ACC_W + 1;     // intermediate plus addend
  localparam int PROD_W  = MAG_W + T_W;   // shared multiplier product
  localparam int RND_W   = PROD_W - QBITS;
  localparam int COEF_W  = 32;
  localparam int NUM_W   = 11;            // hundredths numerator, signed
  localparam int NMAG_W  = NUM_W - 1;
  localparam int OSH     = QBITS - FRAC_BITS;
  localparam int OVF_SH  = MAG_W - QBITS;
  localparam int CNT_W   = $clog2(MAG_W);
  localparam int ITER_W  = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
  localparam int RES_W   = MAG_W - OSH + 2;

  localparam logic [MAG_W-1:0]  ACC_MAX = '1;
  localparam logic signed [ACC_W-1:0] ACC_MAX_S = {1'b0, ACC_MAX};
  localparam logic [PROD_W-1:0] HALF_Q  = PROD_W'(1) << (QBITS - 1);
  localparam logic [ACC_W-1:0]  HALF_O  = ACC_W'(1) << (OSH - 1);

  // Coefficient n/100 in Q28: n*floor(2^26/25) + floor((14n+12)/25)
  localparam logic [T_W-1:0] COEF_RECIP  = 32'd2684354;
  localparam logic [13:0]    COEF_REM    = 14'd14;
  localparam logic [13:0]    COEF_RND    = 14'd12;
  localparam logic [15:0]    DIV25_RECIP = 16'd41944;   // ceil(2^20/25)
  localparam int             DIV25_SHIFT = 20;
  localparam logic signed [NUM_W-1:0] NUM_ONE = 11'sd100;

  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic signed [EASED_W-1:0] OUT_MIN = -18'sd65536;
  localparam logic signed [EASED_W-1:0] OUT_MAX = 18'sd131071;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X1 = 3'd0,
    CFG_X2 = 3'd1,
    CFG_Y1 = 3'd2,
    CFG_Y2 = 3'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_COEF_MUL,
    S_COEF_WR,
    S_MAC_MUL,
    S_MAC_ADD,
    S_DIV_CHK,
    S_DIV,
    S_UPDATE,
    S_OUT
  } st_t;

  // Coefficient being built
  typedef enum logic [2:0] {
    C_XA, C_XB, C_XC, C_YA, C_YB, C_YC
  } coef_sel_t;

  // Multiply-accumulate micro-ops: slope, x(t) - x, then y(t)
  typedef enum logic [2:0] {
    M_SLOPE_A, M_SLOPE_B, M_FX_A, M_FX_B, M_FX_C, M_Y_A, M_Y_B, M_Y_C
  } mop_t;

endpackage

FILE: hdl/cubic_bezier_ease_evaluator_core.sv
// Cubic Bezier easing evaluator: Newton-Raphson search for t, then y(t).
// One shared 33x32 multiplier and a radix-2 divider under a small sequencer.
// Depends on cbe_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, progress in unsigned Q16) takes one word
//   while the sequencer is idle. The result (eased, signed Q16, saturated)
//   appears on the output channel (out_valid/out_ready) and is held in an
//   output register until taken; the next input word is accepted meanwhile.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the four control-point registers; it is always ready and is meant to be
//   written only while the block is idle. Indexes beyond the list are dropped.
// Sequence:
//   The six curve coefficients are built first. Each Newton step runs five
//   multiply-accumulates (multiply, then add), one overflow check, the
//   bit-serial divider and one update, and y(t) follows with all four steps
//   done. A new word is taken only after the result is loaded into the output
//   register and the sequencer is back in idle. A zero slope ends the search
//   early. The bit-serial divider dominates.
// Reset:
//   Control points return to x1=0.42, x2=0.58, y1=0, y2=1; no word is pending.
//   A stalled receiver holds the result; the sequencer waits in its last state.
module cubic_bezier_ease_evaluator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [cbe_pkg::PROG_W-1:0]            progress,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cbe_pkg::EASED_W-1:0]    eased,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cbe_pkg::CTRL_W-1:0]            cfg_data
);
  import cbe_pkg::*;

  // Control state
  st_t                     state, state_next;
  mop_t                    mop;
  coef_sel_t               csel;
  logic [ITER_W-1:0]       iter;
  logic [CTRL_W-1:0]       ctrl_x1, ctrl_x2, ctrl_y1, ctrl_y2;
  logic                    out_load;

  // Datapath registers
  logic signed [COEF_W-1:0] coef_xa, coef_xb, coef_xc, coef_ya, coef_yb, coef_yc;
  logic signed [T_W-1:0]    val, t;
  logic signed [ACC_W-1:0]  acc, slope;
  logic [PROD_W-1:0]        prod;
  logic [NMAG_W-1:0]        rq;
  logic                     coef_neg, mac_neg, q_neg;
  logic [MAG_W-1:0]         rem, feed, quot;
  logic [CNT_W-1:0]         div_cnt;

  // Combinational datapath
  logic signed [NUM_W-1:0]  h1, h2, g1, g2, num;
  logic [NUM_W-1:0]         num_abs;
  logic [NMAG_W-1:0]        nmag;
  logic [13:0]              rq_in;
  logic [29:0]              rq_prod;
  logic [T_W-1:0]           cmag;
  logic signed [ACC_W-1:0]  mac_a;
  logic signed [ADD_W-1:0]  mac_add;
  logic [ACC_W-1:0]         a_abs;
  logic [T_W-1:0]           t_mag;
  logic [MAG_W-1:0]         mul_a;
  logic [T_W-1:0]           mul_b;
  logic [PROD_W-1:0]        rnd;
  logic [RND_W-1:0]         rq_mul;
  logic [MAG_W-1:0]         s_mag;
  logic signed [ADD_W-1:0]  s_sgn, mac_sum;
  logic signed [ACC_W-1:0]  mac_res;
  logic [ACC_W-1:0]         f_abs, sl_abs;
  logic [MAG_W-1:0]         f_mag, sl_mag;
  logic                     div_ovf, div_ge;
  logic [MAG_W:0]           trial;
  logic signed [ADD_W-1:0]  q_sgn, t_diff;
  logic signed [T_W-1:0]    t_upd;
  logic [ACC_W-1:0]         y_abs, y_sum;
  logic [RES_W-2:0]         y_m;
  logic signed [RES_W-1:0]  y_res;
  logic signed [EASED_W-1:0] eased_next;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_x1 <= 7'd42;
      ctrl_x2 <= 7'd58;
      ctrl_y1 <= 7'd0;
      ctrl_y2 <= 7'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X1:  ctrl_x1 <= cfg_data;
        CFG_X2:  ctrl_x2 <= cfg_data;
        CFG_Y1:  ctrl_y1 <= cfg_data;
        CFG_Y2:  ctrl_y2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hundredths numerators of the coefficients
  assign h1 = signed'(NUM_W'(ctrl_x1));
  assign h2 = signed'(NUM_W'(ctrl_x2));
  assign g1 = signed'(NUM_W'(ctrl_y1));
  assign g2 = signed'(NUM_W'(ctrl_y2));

  always_comb begin
    case (csel)
      C_XA:    num = NUM_ONE - 11'sd3 * h2 + 11'sd3 * h1;
      C_XB:    num = 11'sd3 * h2 - 11'sd6 * h1;
      C_XC:    num = 11'sd3 * h1;
      C_YA:    num = NUM_ONE - 11'sd3 * g2 + 11'sd3 * g1;
      C_YB:    num = 11'sd3 * g2 - 11'sd6 * g1;
      C_YC:    num = 11'sd3 * g1;
      default: num = '0;
    endcase
  end

  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign nmag    = num_abs[NMAG_W-1:0];
  // Rounding remainder term: floor((14n + 12) / 25) by reciprocal
  assign rq_in   = 14'(nmag) * COEF_REM + COEF_RND;
  assign rq_prod = rq_in * DIV25_RECIP;
  assign cmag    = prod[T_W-1:0] + T_W'(rq);

  // Operand and addend of the current multiply-accumulate
  always_comb begin
    case (mop)
      M_SLOPE_A: begin
        mac_a   = (ACC_W'(coef_xa) <<< 1) + ACC_W'(coef_xa);
        mac_add = ADD_W'(coef_xb) <<< 1;
      end
      M_SLOPE_B: begin
        mac_a   = acc;
        mac_add = ADD_W'(coef_xc);
      end
      M_FX_A: begin
        mac_a   = ACC_W'(coef_xa);
        mac_add = ADD_W'(coef_xb);
      end
      M_FX_B: begin
        mac_a   = acc;
        mac_add = ADD_W'(coef_xc);
      end
      M_FX_C: begin
        mac_a   = acc;
        mac_add = -ADD_W'(val);
      end
      M_Y_A: begin
        mac_a   = ACC_W'(coef_ya);
        mac_add = ADD_W'(coef_yb);
      end
      M_Y_B: begin
        mac_a   = acc;
        mac_add = ADD_W'(coef_yc);
      end
      M_Y_C: begin
        mac_a   = acc;
        mac_add = '0;
      end
      default: begin
        mac_a   = acc;
        mac_add = '0;
      end
    endcase
  end

  assign a_abs = mac_a[ACC_W-1] ? ACC_W'(-mac_a) : ACC_W'(mac_a);
  assign t_mag = t[T_W-1] ? T_W'(-t) : T_W'(t);

  // Shared multiplier operands
  always_comb begin
    if (state == S_COEF_MUL) begin
      mul_a = MAG_W'(nmag);
      mul_b = COEF_RECIP;
    end else begin
      mul_a = a_abs[MAG_W-1:0];
      mul_b = t_mag;
    end
  end

  // Round the product to Q28, saturate, apply sign, add, saturate
  assign rnd     = prod + HALF_Q;
  assign rq_mul  = rnd[PROD_W-1:QBITS];
  assign s_mag   = (rq_mul > RND_W'(ACC_MAX)) ? ACC_MAX : rq_mul[MAG_W-1:0];
  assign s_sgn   = mac_neg ? -signed'(ADD_W'(s_mag)) : signed'(ADD_W'(s_mag));
  assign mac_sum = s_sgn + mac_add;

  always_comb begin
    if (mac_sum > ADD_W'(ACC_MAX_S))
      mac_res = ACC_MAX_S;
    else if (mac_sum < -ADD_W'(ACC_MAX_S))
      mac_res = -ACC_MAX_S;
    else
      mac_res = mac_sum[ACC_W-1:0];
  end

  // Divider: |x(t) - x| * 2^28 / |slope|
  assign f_abs   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign sl_abs  = slope[ACC_W-1] ? ACC_W'(-slope) : ACC_W'(slope);
  assign f_mag   = f_abs[MAG_W-1:0];
  assign sl_mag  = sl_abs[MAG_W-1:0];
  assign div_ovf = {{OVF_SH{1'b0}}, f_mag} >= {sl_mag, {OVF_SH{1'b0}}};
  assign trial   = {rem, feed[MAG_W-1]};
  assign div_ge  = trial >= {1'b0, sl_mag};

  // Newton update t - q, saturated to the range of t
  assign q_sgn  = q_neg ? -signed'(ADD_W'(quot)) : signed'(ADD_W'(quot));
  assign t_diff = ADD_W'(t) - q_sgn;

  always_comb begin
    if (t_diff > ADD_W'(T_MAX))
      t_upd = T_MAX;
    else if (t_diff < ADD_W'(T_MIN))
      t_upd = T_MIN;
    else
      t_upd = t_diff[T_W-1:0];
  end

  // Output rounding to Q16 and saturation
  assign y_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign y_sum = y_abs + HALF_O;
  assign y_m   = y_sum[ACC_W-1:OSH];
  assign y_res = acc[ACC_W-1] ? -signed'({1'b0, y_m}) : signed'({1'b0, y_m});

  always_comb begin
    if (y_res < RES_W'(OUT_MIN))
      eased_next = OUT_MIN;
    else if (y_res > RES_W'(OUT_MAX))
      eased_next = OUT_MAX;
    else
      eased_next = y_res[EASED_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_COEF_MUL;
      S_COEF_MUL: state_next = S_COEF_WR;
      S_COEF_WR:  state_next = (csel == C_YC) ? S_MAC_MUL : S_COEF_MUL;
      S_MAC_MUL:  state_next = S_MAC_ADD;
      S_MAC_ADD: begin
        if (mop == M_FX_C)
          state_next = S_DIV_CHK;
        else if (mop == M_Y_C)
          state_next = S_OUT;
        else
          state_next = S_MAC_MUL;
      end
      S_DIV_CHK:  state_next = div_ovf ? S_UPDATE : S_DIV;
      S_DIV:      if (div_cnt == '0) state_next = S_UPDATE;
      S_UPDATE:   state_next = S_MAC_MUL;
      S_OUT:      if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready = (state == S_IDLE);
    out_load = (state == S_OUT) && (!out_valid || out_ready);
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mop       <= M_SLOPE_A;
      csel      <= C_XA;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mop  <= M_SLOPE_A;
            csel <= C_XA;
            iter <= '0;
          end
        end
        S_COEF_WR: begin
          if (csel != C_YC) csel <= coef_sel_t'(csel + 3'd1);
        end
        S_MAC_ADD: begin
          // a zero slope ends the search with the current t
          if (mop == M_SLOPE_B && mac_res == '0)
            mop <= M_Y_A;
          else if (mop != M_FX_C && mop != M_Y_C)
            mop <= mop_t'(mop + 3'd1);
        end
        S_UPDATE: begin
          if (iter == ITER_W'(NEWTON_STEPS - 1)) begin
            mop <= M_Y_A;
          end else begin
            mop  <= M_SLOPE_A;
            iter <= iter + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          val <= signed'(T_W'({progress, {OSH{1'b0}}}));
          t   <= signed'(T_W'({progress, {OSH{1'b0}}}));
        end
      end
      S_COEF_MUL: begin
        prod     <= mul_a * mul_b;
        rq       <= rq_prod[DIV25_SHIFT +: NMAG_W];
        coef_neg <= num[NUM_W-1];
      end
      S_COEF_WR: begin
        case (csel)
          C_XA:    coef_xa <= coef_neg ? -signed'(cmag) : signed'(cmag);
          C_XB:    coef_xb <= coef_neg ? -signed'(cmag) : signed'(cmag);
          C_XC:    coef_xc <= coef_neg ? -signed'(cmag) : signed'(cmag);
          C_YA:    coef_ya <= coef_neg ? -signed'(cmag) : signed'(cmag);
          C_YB:    coef_yb <= coef_neg ? -signed'(cmag) : signed'(cmag);
          C_YC:    coef_yc <= coef_neg ? -signed'(cmag) : signed'(cmag);
          default: ;
        endcase
      end
      S_MAC_MUL: begin
        prod    <= mul_a * mul_b;
        mac_neg <= mac_a[ACC_W-1] ^ t[T_W-1];
      end
      S_MAC_ADD: begin
        acc <= mac_res;
        if (mop == M_SLOPE_B) slope <= mac_res;
      end
      S_DIV_CHK: begin
        q_neg   <= acc[ACC_W-1] ^ slope[ACC_W-1];
        rem     <= MAG_W'(f_mag[MAG_W-1:OVF_SH]);
        feed    <= {f_mag[OVF_SH-1:0], {QBITS{1'b0}}};
        quot    <= div_ovf ? ACC_MAX : '0;
        div_cnt <= CNT_W'(MAG_W - 1);
      end
      S_DIV: begin
        // one quotient bit per cycle, remainder stays below the divisor
        rem     <= div_ge ? MAG_W'(trial - {1'b0, sl_mag}) : trial[MAG_W-1:0];
        quot    <= {quot[MAG_W-2:0], div_ge};
        feed    <= feed << 1;
        div_cnt <= div_cnt - 1'b1;
      end
      S_UPDATE: t <= t_upd;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) eased <= eased_next;
  end

  // Checks
  a_div_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < sl_mag))
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_CHK) |-> (slope != '0))
    else $error("division entered with zero slope");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_CHK) |-> ((acc <= ACC_MAX_S) && (acc >= -ACC_MAX_S)))
    else $error("intermediate outside saturation range");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ((state == S_COEF_MUL) && (csel == C_XA)
                                && (mop == M_SLOPE_A)))
    else $error("accepted word did not start the coefficient pass");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result word raised outside the output state");

endmodule
